>>> hw/rtl/bbe_pkg.sv
// Shared types and constants for the edge-adaptive 3x3 box blur.
`default_nettype none
package bbe_pkg;

  localparam int CH_W       = 8;
  localparam int IMG_W_W    = 12;
  localparam int IMG_H_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 12;
  localparam int NUM_W      = 13;
  localparam int CNT_W      = 4;
  localparam int Q_STEPS    = 8;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    rgb_t older;
    rgb_t newer;
  } line_entry_t;

  typedef rgb_t [2:0][2:0] blk_t;

  typedef struct packed {
    logic       start;
    logic [8:0] mask;
  } mean_req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PIX,
    ST_DRN0,
    ST_DRN1,
    ST_DRN2,
    ST_CALC,
    ST_MEAN,
    ST_LOAD
  } state_t;

endpackage
`default_nettype wire

>>> hw/rtl/bbe_line_store.sv
// Line store memory holding the two previous rows side by side in one entry.
`default_nettype none
module bbe_line_store
  import bbe_pkg::*;
#(
  parameter int DEPTH = 2048,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic        clk,
  input  wire logic        rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output line_entry_t      rd_data,
  input  wire logic        wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire line_entry_t wr_data
);

  line_entry_t mem [DEPTH];
  line_entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule
`default_nettype wire

>>> hw/rtl/bbe_mean.sv
// Masked 3x3 sum and serial rounded division, three color channels in parallel.
`default_nettype none
module bbe_mean
  import bbe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire mean_req_t req,
  input  wire blk_t      blk,
  output logic           done,
  output rgb_t           res
);

  logic [SUM_W-1:0] sum_c [3];
  logic [CNT_W-1:0] cnt_c;
  logic [NUM_W-1:0] rem_r [3];
  logic [CH_W-1:0]  q_r   [3];
  logic [NUM_W-1:0] dsh_r;
  logic [2:0]       step_r;
  logic             busy_r;
  logic             done_r;

  function automatic logic [CH_W-1:0] chan(rgb_t p, int ch);
    logic [CH_W-1:0] v;
    case (ch)
      0:       v = p.red;
      1:       v = p.green;
      default: v = p.blue;
    endcase
    return v;
  endfunction

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        for (int ch = 0; ch < 3; ch++) begin
          if (req.mask[r*3+c]) begin
            sum_c[ch] = sum_c[ch] + SUM_W'(chan(blk[r][c], ch));
          end
        end
      end
    end
    cnt_c = CNT_W'($countones(req.mask));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        step_r <= 3'(Q_STEPS - 1);
      end else if (busy_r) begin
        if (step_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        step_r <= step_r - 1'b1;
      end
    end
  end

  // Numerator is 2*sum+count, divisor 2*count; the quotient never exceeds 255, so the
  // divisor starts shifted up by seven and one quotient bit is settled per cycle.
  always_ff @(posedge clk) begin
    if (req.start) begin
      for (int ch = 0; ch < 3; ch++) begin
        rem_r[ch] <= NUM_W'({sum_c[ch], 1'b0}) + NUM_W'(cnt_c);
        q_r[ch]   <= '0;
      end
      dsh_r <= NUM_W'({cnt_c, 1'b0}) << (Q_STEPS - 1);
    end else if (busy_r) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (rem_r[ch] >= dsh_r) begin
          rem_r[ch] <= rem_r[ch] - dsh_r;
          q_r[ch]   <= {q_r[ch][CH_W-2:0], 1'b1};
        end else begin
          q_r[ch]   <= {q_r[ch][CH_W-2:0], 1'b0};
        end
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done      = done_r;
  assign res.red   = q_r[0];
  assign res.green = q_r[1];
  assign res.blue  = q_r[2];

endmodule
`default_nettype wire

>>> hw/rtl/box_blur_3x3_edge_adaptive.sv
// Edge-adaptive 3x3 box blur over a raster RGB stream, top level and control.
//
// Usage: pixels enter on the in_ channel in raster order with in_op at pixel; each
// result on the out_ channel is the rounded mean of a pixel and its neighbours that lie
// inside the image (9, 6 or 4 of them, fewer for one-row or one-column images). A result
// trails its pixel by one row plus one pixel; the bottom row is flushed by drain requests,
// one result per drain. A pixel sent while the bottom row awaits drains, or a drain with
// nothing pending, is taken and gives no result. The user must set image_width and
// image_height on the cfg_ channel while the block is idle; the block does not enforce
// this, and cfg_ready is always high. Every request is handled on its own: the next
// request is taken only once the last is done and its result, if any, is loaded into
// the output register. A row-end pixel can give two results, one after the other. Each
// result passes through the bit-serial divider, and the line store has one read port,
// so a drain reads its three columns on successive cycles.
// Reset clears counters and control; the line store is not cleared and every entry is
// written before it counts in any result. A stalled receiver holds the output register;
// one more request is taken meanwhile and waits for that register to drain.
`default_nettype none
module box_blur_3x3_edge_adaptive
  import bbe_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_op,
  input  wire logic [CH_W-1:0]       in_red_in,
  input  wire logic [CH_W-1:0]       in_green_in,
  input  wire logic [CH_W-1:0]       in_blue_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [CH_W-1:0]            out_red_out,
  output logic [CH_W-1:0]            out_green_out,
  output logic [CH_W-1:0]            out_blue_out,
  output logic                       out_frame_end,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;

  state_t               state_r, state_nxt;
  logic [IMG_W_W-1:0]   img_w_r;
  logic [IMG_H_W-1:0]   img_h_r;
  logic [CW-1:0]        in_col_r, in_col_nxt;
  logic [IMG_H_W-1:0]   in_row_r, in_row_nxt;
  logic [CW-1:0]        drn_col_r, drn_col_nxt;
  logic                 drn_pend_r, drn_pend_nxt;
  logic                 drn_top_r, drn_top_nxt;
  logic                 second_r, second_nxt;
  logic                 out_valid_r, out_valid_nxt;

  rgb_t                 pix_r, pix_nxt;
  blk_t                 win_r, win_nxt;
  blk_t                 drn_blk_r, drn_blk_nxt;
  logic                 src_drn_r, src_drn_nxt;
  logic [8:0]           mask_r, mask_nxt;
  logic [8:0]           mask_b_r, mask_b_nxt;
  logic                 fend_r, fend_nxt;
  rgb_t                 out_pix_r;
  logic                 out_fend_r;
  logic                 out_load;

  logic [WW-1:0]        w_ext;
  logic [CW-1:0]        w_m1;
  logic [IMG_H_W-1:0]   h_m1;
  logic                 pix_last;
  logic                 drn_last;
  logic                 need_a;
  logic                 need_b;
  logic [8:0]           mask_a;
  logic [8:0]           mask_bv;

  logic                 mem_rd_en;
  logic [CW-1:0]        mem_rd_addr;
  line_entry_t          mem_rd_data;
  logic                 mem_wr_en;
  line_entry_t          mem_wr_data;

  mean_req_t            mean_req;
  blk_t                 mean_blk;
  logic                 mean_done;
  rgb_t                 mean_res;

  // Bit r*3+c is set when row r and column c of the block both take part.
  function automatic logic [8:0] build_mask(logic [2:0] rows, logic [2:0] cols);
    logic [8:0] m;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        m[r*3+c] = rows[r] & cols[c];
      end
    end
    return m;
  endfunction

  always_comb begin
    w_ext = WW'(img_w_r);
    if (img_w_r == '0) begin
      w_m1 = '0;
    end else if (w_ext > WW'(MAX_WIDTH)) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(w_ext - WW'(1));
    end
    h_m1 = (img_h_r == '0) ? '0 : img_h_r - 1'b1;
  end

  assign pix_last = in_col_r >= w_m1;
  assign drn_last = drn_col_r >= w_m1;
  assign need_a   = (in_row_r != '0) && (in_col_r != '0);
  assign need_b   = (in_row_r != '0) && pix_last;
  assign mask_a   = build_mask({2'b11, in_row_r >= IMG_H_W'(2)},
                               {2'b11, in_col_r >= CW'(2)});
  assign mask_bv  = build_mask({2'b11, in_row_r >= IMG_H_W'(2)},
                               {1'b1, in_col_r != '0, 1'b0});

  always_comb begin
    state_nxt    = state_r;
    in_col_nxt   = in_col_r;
    in_row_nxt   = in_row_r;
    drn_col_nxt  = drn_col_r;
    drn_pend_nxt = drn_pend_r;
    drn_top_nxt  = drn_top_r;
    second_nxt   = second_r;
    pix_nxt      = pix_r;
    win_nxt      = win_r;
    drn_blk_nxt  = drn_blk_r;
    src_drn_nxt  = src_drn_r;
    mask_nxt     = mask_r;
    mask_b_nxt   = mask_b_r;
    fend_nxt     = fend_r;
    in_ready     = 1'b0;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = in_col_r;
    mem_wr_en    = 1'b0;
    mem_wr_data.older = (in_row_r != '0) ? mem_rd_data.newer : mem_rd_data.older;
    mem_wr_data.newer = pix_r;
    mean_req.start = 1'b0;
    mean_req.mask  = mask_r;
    out_load       = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_op == OP_DRAIN) begin
            if (drn_pend_r) begin
              mem_rd_en   = 1'b1;
              mem_rd_addr = drn_col_r - 1'b1;
              state_nxt   = ST_DRN0;
            end
          end else if (!drn_pend_r) begin
            mem_rd_en     = 1'b1;
            mem_rd_addr   = in_col_r;
            pix_nxt.red   = in_red_in;
            pix_nxt.green = in_green_in;
            pix_nxt.blue  = in_blue_in;
            state_nxt     = ST_PIX;
          end
        end
      end
      ST_PIX: begin
        mem_wr_en = 1'b1;
        for (int r = 0; r < 3; r++) begin
          win_nxt[r][0] = win_r[r][1];
          win_nxt[r][1] = win_r[r][2];
        end
        win_nxt[0][2] = mem_rd_data.older;
        win_nxt[1][2] = mem_rd_data.newer;
        win_nxt[2][2] = pix_r;
        src_drn_nxt   = 1'b0;
        fend_nxt      = 1'b0;
        mask_b_nxt    = mask_bv;
        if (need_a) begin
          mask_nxt   = mask_a;
          second_nxt = need_b;
          state_nxt  = ST_CALC;
        end else if (need_b) begin
          mask_nxt   = mask_bv;
          second_nxt = 1'b0;
          state_nxt  = ST_CALC;
        end else begin
          second_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
        if (pix_last) begin
          in_col_nxt = '0;
          if (in_row_r >= h_m1) begin
            drn_pend_nxt = 1'b1;
            drn_top_nxt  = in_row_r != '0;
            drn_col_nxt  = '0;
            in_row_nxt   = '0;
          end else begin
            in_row_nxt = in_row_r + 1'b1;
          end
        end else begin
          in_col_nxt = in_col_r + 1'b1;
        end
      end
      ST_DRN0: begin
        drn_blk_nxt[0][0] = mem_rd_data.older;
        drn_blk_nxt[1][0] = mem_rd_data.newer;
        drn_blk_nxt[2][0] = '0;
        mem_rd_en         = 1'b1;
        mem_rd_addr       = drn_col_r;
        state_nxt         = ST_DRN1;
      end
      ST_DRN1: begin
        drn_blk_nxt[0][1] = mem_rd_data.older;
        drn_blk_nxt[1][1] = mem_rd_data.newer;
        drn_blk_nxt[2][1] = '0;
        mem_rd_en         = 1'b1;
        mem_rd_addr       = drn_col_r + 1'b1;
        state_nxt         = ST_DRN2;
      end
      ST_DRN2: begin
        drn_blk_nxt[0][2] = mem_rd_data.older;
        drn_blk_nxt[1][2] = mem_rd_data.newer;
        drn_blk_nxt[2][2] = '0;
        mask_nxt    = build_mask({1'b0, 1'b1, drn_top_r},
                                 {!drn_last, 1'b1, drn_col_r != '0});
        src_drn_nxt = 1'b1;
        fend_nxt    = drn_last;
        second_nxt  = 1'b0;
        if (drn_last) begin
          drn_pend_nxt = 1'b0;
          drn_col_nxt  = '0;
        end else begin
          drn_col_nxt = drn_col_r + 1'b1;
        end
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        mean_req.start = 1'b1;
        state_nxt      = ST_MEAN;
      end
      ST_MEAN: begin
        if (mean_done) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          if (second_r) begin
            mask_nxt   = mask_b_r;
            second_nxt = 1'b0;
            fend_nxt   = 1'b0;
            state_nxt  = ST_CALC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      img_w_r     <= IMG_W_W'(2048);
      img_h_r     <= IMG_H_W'(1);
      in_col_r    <= '0;
      in_row_r    <= '0;
      drn_col_r   <= '0;
      drn_pend_r  <= 1'b0;
      drn_top_r   <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_col_r    <= in_col_nxt;
      in_row_r    <= in_row_nxt;
      drn_col_r   <= drn_col_nxt;
      drn_pend_r  <= drn_pend_nxt;
      drn_top_r   <= drn_top_nxt;
      second_r    <= second_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  img_w_r <= cfg_data[IMG_W_W-1:0];
          REG_IMAGE_HEIGHT: img_h_r <= cfg_data[IMG_H_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    pix_r     <= pix_nxt;
    win_r     <= win_nxt;
    drn_blk_r <= drn_blk_nxt;
    src_drn_r <= src_drn_nxt;
    mask_r    <= mask_nxt;
    mask_b_r  <= mask_b_nxt;
    fend_r    <= fend_nxt;
    if (out_load) begin
      out_pix_r  <= mean_res;
      out_fend_r <= fend_r;
    end
  end

  assign mean_blk = src_drn_r ? drn_blk_r : win_r;

  bbe_line_store #(
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (in_col_r),
    .wr_data (mem_wr_data)
  );

  bbe_mean u_mean (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mean_req),
    .blk   (mean_blk),
    .done  (mean_done),
    .res   (mean_res)
  );

  assign cfg_ready     = 1'b1;
  assign out_valid     = out_valid_r;
  assign out_red_out   = out_pix_r.red;
  assign out_green_out = out_pix_r.green;
  assign out_blue_out  = out_pix_r.blue;
  assign out_frame_end = out_fend_r;

endmodule
`default_nettype wire
